// ===== sv/fct_pkg.sv =====
package fct_pkg;

  localparam int PlaneCount = 6;
  localparam int PlaneIdxW = 3;
  localparam int CfgDataW = 64;
  localparam int NormW = 12;
  localparam int OffW = 28;
  localparam int PosW = 24;
  localparam int HalfW = 23;
  localparam int ProdW = 36;
  localparam int SumW = 40;

  localparam logic [PlaneIdxW-1:0] IdxNear = 3'd0;
  localparam logic [PlaneIdxW-1:0] IdxFar = 3'd1;

  typedef enum logic [1:0] {
    CLASS_OUTSIDE = 2'd0,
    CLASS_INTERSECTS = 2'd1,
    CLASS_INSIDE = 2'd2
  } class_t;

  typedef struct packed {
    logic mode;
    logic signed [PosW-1:0] center_x;
    logic signed [PosW-1:0] center_y;
    logic signed [PosW-1:0] center_z;
    logic [HalfW-1:0] half_x;
    logic [HalfW-1:0] half_y;
    logic [HalfW-1:0] half_z;
    logic [HalfW-1:0] sphere_radius;
    logic skip_depth;
  } item_t;

  typedef struct packed {
    logic [1:0] classification;
    logic visible;
  } result_t;

endpackage

// ===== sv/fct_if.sv =====
interface fct_item_if;
  import fct_pkg::*;
  logic valid;
  logic ready;
  item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface fct_result_if;
  import fct_pkg::*;
  logic valid;
  logic ready;
  result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== sv/frustum_cull_test_core.sv =====
// Channel   Direction  Payload
// item_in   sink       mode, center_x/y/z, half_x/y/z, sphere_radius, skip_depth
// res_out   source     classification, visible
// cfg       write      cfg_we, cfg_index, cfg_data (six 64-bit planes)
//
// Four register stages: products, plane sums, per-plane tests, verdict.
// One transaction per cycle while the output stage is not held by res_out.ready.
// All six planes are tested in parallel, one multiplier set per plane.
// Synchronous reset clears valid bits and planes to zero.
// A stall freezes every stage; ready falls only when the output stage is held.
module frustum_cull_test_core (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [fct_pkg::PlaneIdxW-1:0] cfg_index,
  input  logic [fct_pkg::CfgDataW-1:0] cfg_data,
  fct_item_if.sink item_in,
  fct_result_if.source res_out
);
  import fct_pkg::*;

  logic [CfgDataW-1:0] planes [PlaneCount];

  logic adv;
  logic v1, v2, v3, v4;

  logic signed [ProdW-1:0] pc [PlaneCount][3];
  logic signed [ProdW-1:0] pr [PlaneCount][3];
  logic signed [OffW-1:0] pd1 [PlaneCount];
  logic mode1, skip1;
  logic signed [SumW-1:0] rad1;

  logic signed [SumW-1:0] dist2 [PlaneCount];
  logic signed [SumW-1:0] r2 [PlaneCount];
  logic mode2, skip2;

  logic [PlaneCount-1:0] out3, str3;
  logic skip3;

  result_t res4;

  assign adv = !v4 || res_out.ready;
  assign item_in.ready = adv;
  assign res_out.valid = v4;
  assign res_out.data = res4;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PlaneCount; i++) planes[i] <= '0;
    end else if (cfg_we && cfg_index < PlaneIdxW'(PlaneCount)) begin
      planes[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= item_in.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode1 <= item_in.data.mode;
      skip1 <= item_in.data.skip_depth;
      rad1 <= SumW'($signed({1'b0, item_in.data.sphere_radius, 10'd0}));
      for (int i = 0; i < PlaneCount; i++) begin
        logic signed [NormW-1:0] n [3];
        logic [NormW-1:0] an [3];
        n[0] = planes[i][11:0];
        n[1] = planes[i][23:12];
        n[2] = planes[i][35:24];
        for (int k = 0; k < 3; k++) an[k] = n[k][NormW-1] ? -n[k] : n[k];
        pd1[i] <= planes[i][63:36];
        pc[i][0] <= ProdW'(n[0] * item_in.data.center_x);
        pc[i][1] <= ProdW'(n[1] * item_in.data.center_y);
        pc[i][2] <= ProdW'(n[2] * item_in.data.center_z);
        pr[i][0] <= $signed(ProdW'(an[0]) * ProdW'(item_in.data.half_x));
        pr[i][1] <= $signed(ProdW'(an[1]) * ProdW'(item_in.data.half_y));
        pr[i][2] <= $signed(ProdW'(an[2]) * ProdW'(item_in.data.half_z));
      end

      mode2 <= mode1;
      skip2 <= skip1;
      for (int i = 0; i < PlaneCount; i++) begin
        dist2[i] <= SumW'(pc[i][0]) + SumW'(pc[i][1]) + SumW'(pc[i][2])
                    + SumW'($signed({pd1[i], 10'd0}));
        r2[i] <= mode1 ? rad1
                       : SumW'(pr[i][0]) + SumW'(pr[i][1]) + SumW'(pr[i][2]);
      end

      skip3 <= skip2;
      for (int i = 0; i < PlaneCount; i++) begin
        if (mode2) begin
          out3[i] <= dist2[i] < -r2[i];
          str3[i] <= (dist2[i] < r2[i]) && (-dist2[i] < r2[i]);
        end else begin
          out3[i] <= (dist2[i] + r2[i]) < 0;
          str3[i] <= (dist2[i] - r2[i]) < 0;
        end
      end

      begin
        logic [PlaneCount-1:0] m;
        m = '1;
        if (skip3) begin
          m[IdxNear] = 1'b0;
          m[IdxFar] = 1'b0;
        end
        if (|(out3 & m)) res4 <= '{CLASS_OUTSIDE, 1'b0};
        else if (|(str3 & m)) res4 <= '{CLASS_INTERSECTS, 1'b1};
        else res4 <= '{CLASS_INSIDE, 1'b1};
      end
    end
  end

endmodule

// ===== bench/fct_tb_if.sv =====
`timescale 1ns / 100ps

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import fct_pkg::*;

  localparam int Latency = 4;
  localparam longint CycleLimit = 400000;
  localparam int IdxLeft = 2;
  localparam int IdxRight = 3;
  localparam int IdxTop = 4;
  localparam int IdxBottom = 5;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [PlaneIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  fct_item_if item_in();
  fct_result_if res_out();

  frustum_cull_test_core i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_in(item_in), .res_out(res_out)
  );

  logic [CfgDataW-1:0] plane_regs [PlaneCount];
  result_t verdict_q [$];
  int mismatches = 0;
  longint cycles = 0;
  bit allow_idle = 1'b1;
  bit hold_req = 1'b0;
  int hold_off = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic longint sx(logic [63:0] v, int w);
    longint r;
    r = longint'(v << (64 - w));
    return r >>> (64 - w);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic result_t classify(item_t it);
    result_t res;
    class_t cls;
    bit strad;
    longint nx, ny, nz, pd, pdist, r, rad;
    cls = CLASS_INSIDE;
    strad = 1'b0;
    rad = longint'(it.sphere_radius) * 1024;
    for (int i = 0; i < PlaneCount; i++) begin
      if (it.skip_depth && (i == IdxNear || i == IdxFar)) continue;
      nx = sx(plane_regs[i], NormW);
      ny = sx(plane_regs[i] >> 12, NormW);
      nz = sx(plane_regs[i] >> 24, NormW);
      pd = sx(plane_regs[i] >> 36, OffW);
      pdist = nx * longint'(it.center_x) + ny * longint'(it.center_y)
            + nz * longint'(it.center_z) + pd * 1024;
      if (!it.mode) begin
        r = mag(nx) * longint'(it.half_x) + mag(ny) * longint'(it.half_y)
          + mag(nz) * longint'(it.half_z);
        if (pdist + r < 0) begin
          cls = CLASS_OUTSIDE;
          break;
        end
        if (pdist - r < 0) strad = 1'b1;
      end else begin
        if (pdist < -rad) begin
          cls = CLASS_OUTSIDE;
          break;
        end
        if (mag(pdist) < rad) strad = 1'b1;
      end
    end
    if (cls != CLASS_OUTSIDE && strad) cls = CLASS_INTERSECTS;
    res.classification = cls;
    res.visible = (cls != CLASS_OUTSIDE);
    return res;
  endfunction

  // receiver: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      res_out.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_off <= 200;
      res_out.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res_out.ready <= 1'b0;
    end else if (allow_idle && $urandom_range(0, 7) == 0) begin
      hold_off <= $urandom_range(0, 10);
      res_out.ready <= 1'b0;
    end else begin
      res_out.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && res_out.valid && res_out.ready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %p", res_out.data);
      end else begin
        exp_r = verdict_q.pop_front();
        if (res_out.data.classification !== exp_r.classification ||
            res_out.data.visible !== exp_r.visible) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected cls=%0d vis=%0d actual cls=%0d vis=%0d",
                     exp_r.classification, exp_r.visible,
                     res_out.data.classification, res_out.data.visible);
        end
      end
    end
  end

  task automatic send(item_t it);
    int gap;
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      item_in.valid <= 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(posedge clk);
    end
    item_in.valid <= 1'b1;
    item_in.data <= it;
    do @(posedge clk); while (!item_in.ready);
    verdict_q.push_back(classify(it));
  endtask

  task automatic go_idle();
    item_in.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (Latency + 2) @(posedge clk);
  endtask

  task automatic write_plane(int idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= PlaneIdxW'(idx);
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    plane_regs[idx] = val;
    @(posedge clk);
  endtask

  function automatic logic [63:0] pack_plane(int nx, int ny, int nz, int d);
    return {d[OffW-1:0], nz[NormW-1:0], ny[NormW-1:0], nx[NormW-1:0]};
  endfunction

  function automatic item_t rand_item(int span);
    item_t it;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    if (span < PosW) begin
      it.center_x = PosW'($signed($urandom_range(0, 2 ** span)) - 2 ** (span - 1));
      it.center_y = PosW'($signed($urandom_range(0, 2 ** span)) - 2 ** (span - 1));
      it.center_z = PosW'($signed($urandom_range(0, 2 ** span)) - 2 ** (span - 1));
      it.half_x = HalfW'($urandom_range(0, 2 ** (span - 2)));
      it.half_y = HalfW'($urandom_range(0, 2 ** (span - 2)));
      it.half_z = HalfW'($urandom_range(0, 2 ** (span - 2)));
      it.sphere_radius = HalfW'($urandom_range(0, 2 ** (span - 1)));
    end
    return it;
  endfunction

  // axis-aligned box frustum around the origin, extent e in whole Q.8 units (offset e * 256)
  task automatic load_box_frustum(int e);
    write_plane(int'(IdxNear), pack_plane(0, 0, 1024, e * 256));
    write_plane(int'(IdxFar), pack_plane(0, 0, -1024, e * 256));
    write_plane(IdxLeft, pack_plane(1024, 0, 0, e * 256));
    write_plane(IdxRight, pack_plane(-1024, 0, 0, e * 256));
    write_plane(IdxTop, pack_plane(0, -1024, 0, e * 256));
    write_plane(IdxBottom, pack_plane(0, 1024, 0, e * 256));
  endtask

  task automatic test_reset_planes();
    item_t it;
    it = rand_item(PosW);
    send(it);
    it.mode = 1'b1;
    send(it);
    go_idle();
  endtask

  task automatic test_directed();
    item_t it;
    load_box_frustum(16);
    it = '0;
    send(it);
    it.center_x = 24'sd4096;
    send(it);
    it.center_x = 24'sd4000; it.half_x = 23'd200;
    send(it);
    it.center_x = 24'sd5000; it.half_x = 23'd200;
    send(it);
    it.skip_depth = 1'b1; it.center_x = '0; it.center_z = 24'sd100000;
    send(it);
    it.skip_depth = 1'b0;
    send(it);
    it = '0; it.mode = 1'b1; it.sphere_radius = 23'd300; it.center_y = 24'sd4000;
    send(it);
    it.center_y = 24'sd4500;
    send(it);
    it.center_y = 24'sd4200;
    send(it);
    it.sphere_radius = '0; it.center_y = 24'sd4096;
    send(it);
    it.center_y = 24'sd4097;
    send(it);
    it = '1; it.mode = 1'b0;
    it.center_x = 24'sh800000; it.center_y = 24'sh7fffff; it.center_z = 24'sh800000;
    send(it);
    it.mode = 1'b1;
    send(it);
    it.center_x = 24'sh7fffff;
    send(it);
    go_idle();
    write_plane(int'(IdxNear), {28'h8000000, 12'h800, 12'h800, 12'h800});
    write_plane(int'(IdxFar), {28'h7ffffff, 12'h7ff, 12'h7ff, 12'h7ff});
    write_plane(IdxLeft, '1);
    write_plane(IdxRight, '0);
    write_plane(IdxTop, {28'h7ffffff, 12'h800, 12'h7ff, 12'h001});
    write_plane(IdxBottom, {28'h8000000, 12'h7ff, 12'h800, 12'hfff});
    for (int i = 0; i < 8; i++) send(rand_item(PosW));
    it = '1; it.skip_depth = 1'b0; it.mode = 1'b0;
    send(it);
    it.mode = 1'b1;
    send(it);
    go_idle();
  endtask

  task automatic test_random(int n, bit idle);
    allow_idle = idle;
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 0) begin
        go_idle();
        if ($urandom_range(0, 1)) load_box_frustum($urandom_range(1, 4000));
        else for (int p = 0; p < PlaneCount; p++) write_plane(p, {$urandom, $urandom});
      end
      send(rand_item($urandom_range(0, 3) == 0 ? PosW : $urandom_range(8, 20)));
    end
    go_idle();
  endtask

  task automatic test_backpressure();
    load_box_frustum(64);
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send(rand_item(16));
    go_idle();
  endtask

  initial begin
    int waited;
    item_in.valid = 1'b0;
    item_in.data = '0;
    for (int i = 0; i < PlaneCount; i++) plane_regs[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_planes();
    test_directed();
    test_backpressure();
    test_random(800, 1'b1);
    test_random(350, 1'b0);
    item_in.valid <= 1'b0;
    waited = 0;
    while (verdict_q.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (Latency + 4) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
